/* hw/rtl/pvd_pkg.sv */
`timescale 1ns / 1ps
package pvd_pkg;

	// shortest header that still carries every captured field
	localparam int MIN_HEADER_BYTES = 28;

	// frame start signature "PaVE"
	localparam logic [31:0] SIGNATURE = 32'h5061_5645;

	// largest header plus payload after reset
	localparam logic [24:0] MAX_FRAME_RESET = 25'd65536;

	// header codec byte values
	localparam logic [7:0] HDR_CODEC_AVC = 8'd4;
	localparam logic [7:0] HDR_CODEC_M4V = 8'd3;

	typedef enum logic [2:0] {
		KIND_PAYLOAD  = 3'd0,
		KIND_EMPTY    = 3'd1,
		KIND_OVERSIZE = 3'd2,
		KIND_RESTART  = 3'd3,
		KIND_SHORT    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CODEC_AVC     = 2'd0,
		CODEC_M4V     = 2'd1,
		CODEC_UNKNOWN = 2'd2
	} codec_t;

	typedef enum logic {
		MODE_BYTE    = 1'b0,
		MODE_RESTART = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic        first_of_frame;
		logic        last_of_frame;
		codec_t      codec;
		logic [15:0] pic_width;
		logic [15:0] pic_height;
		logic [31:0] timestamp_ms;
		logic [23:0] payload_length;
	} result_t;

endpackage

/* hw/rtl/pave_video_deframer_core.sv */
`timescale 1ns / 1ps
// Video deframer: hunts a byte stream for the "PaVE" signature, parses the
// little-endian header that follows and returns every payload byte tagged
// with codec, display size, timestamp, payload length and first/last marks;
// empty, oversize, short-header and restart-cut frames each give one status
// result. One byte is taken every cycle while item_stall is low; its result,
// if any, goes to the output register, or to the one-entry skid stage behind
// it when the output is stalled; that stage raises item_stall, so a stalled
// output side stops the input only once two results are held.
module pave_video_deframer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  pvd_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output pvd_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [24:0]      cfg_data
);

	logic             accept;
	logic             produce;
	logic             take;
	logic [24:0]      max_q;
	pvd_pkg::result_t res;
	pvd_pkg::result_t out_q;
	pvd_pkg::result_t skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;

	assign cfg_ready    = 1'b1;
	assign item_stall   = skid_valid_q;
	assign accept       = item_valid && !skid_valid_q;
	assign take         = out_valid_q && !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// frame size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= pvd_pkg::MAX_FRAME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	pvd_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.beat            (item),
		.max_frame_bytes (max_q),
		.produce         (produce),
		.res             (res)
	);

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && produce) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take)
				out_q <= skid_q;
		end else if (accept && produce) begin
			if (!out_valid_q || take)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

endmodule

/* hw/rtl/pvd_parse.sv */
`timescale 1ns / 1ps
module pvd_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  pvd_pkg::item_t   beat,
	input  logic [24:0]      max_frame_bytes,
	output logic             produce,
	output pvd_pkg::result_t res
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	phase_t               phase_q;
	logic [23:0]          recent_q;
	logic [15:0]          hcount_q;
	logic [23:0]          pcount_q;
	pvd_pkg::codec_t      codec_q;
	logic [15:0]          hsize_q;
	logic [23:0]          psize_q;
	logic                 povf_q;
	logic [15:0]          width_q;
	logic [15:0]          height_q;
	logic [31:0]          ts_q;

	pvd_pkg::codec_t      codec_n;
	logic [15:0]          hsize_n;
	logic [23:0]          psize_n;
	logic                 povf_n;
	logic [15:0]          width_n;
	logic [15:0]          height_n;
	logic [31:0]          ts_n;
	logic [15:0]          hcount_n;
	logic                 cap;
	logic [7:0]           b;
	logic                 hdr_short;
	logic                 hdr_done;
	logic                 oversize;
	logic [24:0]          total;
	logic                 sig_hit;
	logic                 pay_last;

	assign b   = beat.data_byte;
	assign cap = (phase_q == PH_HEADER) && (beat.mode == pvd_pkg::MODE_BYTE);

	// header field capture at the current offset
	always_comb begin
		codec_n  = codec_q;
		hsize_n  = hsize_q;
		psize_n  = psize_q;
		povf_n   = povf_q;
		width_n  = width_q;
		height_n = height_q;
		ts_n     = ts_q;
		if (cap) begin
			case (hcount_q)
				16'd5: begin
					if (b == pvd_pkg::HDR_CODEC_AVC)
						codec_n = pvd_pkg::CODEC_AVC;
					else if (b == pvd_pkg::HDR_CODEC_M4V)
						codec_n = pvd_pkg::CODEC_M4V;
					else
						codec_n = pvd_pkg::CODEC_UNKNOWN;
				end
				16'd6:  hsize_n[7:0]    = b;
				16'd7:  hsize_n[15:8]   = b;
				16'd8:  psize_n[7:0]    = b;
				16'd9:  psize_n[15:8]   = b;
				16'd10: psize_n[23:16]  = b;
				16'd11: povf_n          = (b != 8'd0);
				16'd16: width_n[7:0]    = b;
				16'd17: width_n[15:8]   = b;
				16'd18: height_n[7:0]   = b;
				16'd19: height_n[15:8]  = b;
				16'd24: ts_n[7:0]       = b;
				16'd25: ts_n[15:8]      = b;
				16'd26: ts_n[23:16]     = b;
				16'd27: ts_n[31:24]     = b;
				default: ;
			endcase
		end
	end

	// header checks
	assign hcount_n  = hcount_q + 16'd1;
	assign hdr_short = (hcount_n == 16'd8) && (hsize_n < 16'(pvd_pkg::MIN_HEADER_BYTES));
	assign hdr_done  = (hcount_n >= 16'd8) && (hcount_n == hsize_n);
	assign total     = {9'd0, hsize_n} + {1'b0, psize_n};
	assign oversize  = povf_n || (total > max_frame_bytes);
	assign sig_hit   = ({recent_q, b} == pvd_pkg::SIGNATURE);
	assign pay_last  = (({1'b0, pcount_q} + 25'd1) >= {1'b0, psize_q});

	// result for the current beat
	always_comb begin
		produce            = 1'b0;
		res.kind           = pvd_pkg::KIND_PAYLOAD;
		res.payload_byte   = 8'd0;
		res.first_of_frame = 1'b0;
		res.last_of_frame  = 1'b0;
		res.codec          = codec_n;
		res.pic_width      = width_n;
		res.pic_height     = height_n;
		res.timestamp_ms   = ts_n;
		res.payload_length = psize_n;
		if (beat.mode == pvd_pkg::MODE_RESTART) begin
			if (phase_q == PH_HEADER || phase_q == PH_PAYLOAD) begin
				produce  = 1'b1;
				res.kind = pvd_pkg::KIND_RESTART;
			end
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (hdr_short) begin
						produce  = 1'b1;
						res.kind = pvd_pkg::KIND_SHORT;
					end else if (hdr_done) begin
						if (oversize) begin
							produce  = 1'b1;
							res.kind = pvd_pkg::KIND_OVERSIZE;
						end else if (psize_n == 24'd0) begin
							produce           = 1'b1;
							res.kind          = pvd_pkg::KIND_EMPTY;
							res.last_of_frame = 1'b1;
						end
					end
				end
				PH_PAYLOAD: begin
					produce            = 1'b1;
					res.payload_byte   = b;
					res.first_of_frame = (pcount_q == 24'd0);
					res.last_of_frame  = pay_last;
				end
				default: ;
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			recent_q <= 24'd0;
			hcount_q <= 16'd0;
			pcount_q <= 24'd0;
			codec_q  <= pvd_pkg::CODEC_UNKNOWN;
			hsize_q  <= 16'd0;
			psize_q  <= 24'd0;
			povf_q   <= 1'b0;
			width_q  <= 16'd0;
			height_q <= 16'd0;
			ts_q     <= 32'd0;
		end else if (accept) begin
			if (beat.mode == pvd_pkg::MODE_RESTART) begin
				phase_q  <= PH_HUNT;
				recent_q <= 24'd0;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						codec_q  <= codec_n;
						hsize_q  <= hsize_n;
						psize_q  <= psize_n;
						povf_q   <= povf_n;
						width_q  <= width_n;
						height_q <= height_n;
						ts_q     <= ts_n;
						hcount_q <= hcount_n;
						if (hdr_short) begin
							phase_q  <= PH_HUNT;
							recent_q <= 24'd0;
						end else if (hdr_done) begin
							if (oversize || psize_n == 24'd0) begin
								phase_q  <= PH_HUNT;
								recent_q <= 24'd0;
							end else begin
								pcount_q <= 24'd0;
								phase_q  <= PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						pcount_q <= pcount_q + 24'd1;
						if (pay_last) begin
							phase_q  <= PH_HUNT;
							recent_q <= 24'd0;
						end
					end
					default: begin
						if (sig_hit) begin
							codec_q  <= pvd_pkg::CODEC_UNKNOWN;
							hsize_q  <= 16'd0;
							psize_q  <= 24'd0;
							povf_q   <= 1'b0;
							width_q  <= 16'd0;
							height_q <= 16'd0;
							ts_q     <= 32'd0;
							hcount_q <= 16'd4;
							pcount_q <= 24'd0;
							recent_q <= 24'd0;
							phase_q  <= PH_HEADER;
						end else begin
							phase_q  <= PH_HUNT;
							recent_q <= {recent_q[15:0], b};
						end
					end
				endcase
			end
		end
	end

endmodule

/* hw/rtl/pvd_checker.sv */
`timescale 1ns / 1ps
module pvd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input pvd_pkg::result_t result
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// input is held off only while a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with no result pending");

	// status results carry no byte and no first mark
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != pvd_pkg::KIND_PAYLOAD |->
			result.payload_byte == 8'd0 && !result.first_of_frame)
		else $error("status result carries payload fields");

	// last mark only on payload bytes or empty frames
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_of_frame |->
			result.kind == pvd_pkg::KIND_PAYLOAD || result.kind == pvd_pkg::KIND_EMPTY)
		else $error("last mark on wrong result kind");

	// empty frame announces zero length
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == pvd_pkg::KIND_EMPTY |->
			result.payload_length == 24'd0 && result.last_of_frame)
		else $error("empty frame with nonzero length");

endmodule

bind pave_video_deframer_core pvd_checker u_pvd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

/* bench/tb_pave_video_deframer_core.sv */
`timescale 1ns / 1ps
module tb_pave_video_deframer_core;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int MAX_PRINTS     = 100;

	// byte fill styles for frame building
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZEROS  = 1;
	localparam int FILL_ONES   = 2;

	typedef enum logic [1:0] {
		SEEK_SIGNATURE,
		IN_HEADER,
		IN_BODY
	} parse_phase_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	pvd_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	pvd_pkg::result_t result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [24:0]      cfg_data = '0;

	// predicted deframer state
	parse_phase_t parse_phase = SEEK_SIGNATURE;
	logic [23:0]  sig_history = '0;
	logic [15:0]  hdr_pos = '0;
	logic [23:0]  body_pos = '0;
	logic [7:0]   cap_codec = '0;
	logic [15:0]  cap_hdr_size = '0;
	logic [31:0]  cap_body_size = '0;
	logic [15:0]  cap_width = '0;
	logic [15:0]  cap_height = '0;
	logic [31:0]  cap_stamp = '0;
	logic [24:0]  frame_limit = pvd_pkg::MAX_FRAME_RESET;

	pvd_pkg::result_t expected_results[$];
	pvd_pkg::item_t   outbound[$];

	int queued_total = 0;
	int items_offered = 0;
	int items_taken = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	bit want_hold = 1'b0;

	int send_gap = 0;
	int send_quiet = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stall_left = 0;
	int recv_quiet = 0;

	pave_video_deframer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	// result beat as the deframer reports it from the captured header
	function automatic pvd_pkg::result_t frame_result(pvd_pkg::kind_t k, logic [7:0] b,
			logic first, logic last);
		pvd_pkg::result_t r;
		r.kind = k;
		r.payload_byte = b;
		r.first_of_frame = first;
		r.last_of_frame = last;
		if (cap_codec == pvd_pkg::HDR_CODEC_AVC)
			r.codec = pvd_pkg::CODEC_AVC;
		else if (cap_codec == pvd_pkg::HDR_CODEC_M4V)
			r.codec = pvd_pkg::CODEC_M4V;
		else
			r.codec = pvd_pkg::CODEC_UNKNOWN;
		r.pic_width = cap_width;
		r.pic_height = cap_height;
		r.timestamp_ms = cap_stamp;
		r.payload_length = cap_body_size[23:0];
		return r;
	endfunction

	function automatic void back_to_seek();
		parse_phase = SEEK_SIGNATURE;
		sig_history = '0;
	endfunction

	function automatic void take_header_byte(logic [15:0] pos, logic [7:0] b);
		case (pos)
			16'd5: cap_codec = b;
			16'd6: cap_hdr_size = {8'h00, b};
			16'd7: cap_hdr_size[15:8] = b;
			16'd8, 16'd9, 16'd10, 16'd11: cap_body_size[8 * (pos - 16'd8) +: 8] = b;
			16'd16: cap_width = {8'h00, b};
			16'd17: cap_width[15:8] = b;
			16'd18: cap_height = {8'h00, b};
			16'd19: cap_height[15:8] = b;
			16'd24, 16'd25, 16'd26, 16'd27: cap_stamp[8 * (pos - 16'd24) +: 8] = b;
			default: ;
		endcase
	endfunction

	// advance the predicted deframer by one input beat
	function automatic void predict_item(pvd_pkg::item_t it);
		logic [32:0] total;
		logic        last;
		if (it.mode == pvd_pkg::MODE_RESTART) begin
			if (parse_phase == IN_HEADER || parse_phase == IN_BODY)
				expected_results.push_back(frame_result(pvd_pkg::KIND_RESTART, 8'h00,
					1'b0, 1'b0));
			back_to_seek();
		end else if (parse_phase == IN_HEADER) begin
			take_header_byte(hdr_pos, it.data_byte);
			hdr_pos = hdr_pos + 16'd1;
			if (hdr_pos == 16'd8 && cap_hdr_size < pvd_pkg::MIN_HEADER_BYTES) begin
				expected_results.push_back(frame_result(pvd_pkg::KIND_SHORT, 8'h00,
					1'b0, 1'b0));
				back_to_seek();
			end else if (hdr_pos >= 16'd8 && hdr_pos == cap_hdr_size) begin
				total = {17'd0, cap_hdr_size} + {1'b0, cap_body_size};
				if (total > {8'd0, frame_limit} || cap_body_size > 32'hFF_FFFF) begin
					expected_results.push_back(frame_result(pvd_pkg::KIND_OVERSIZE, 8'h00,
						1'b0, 1'b0));
					back_to_seek();
				end else if (cap_body_size == 32'd0) begin
					expected_results.push_back(frame_result(pvd_pkg::KIND_EMPTY, 8'h00,
						1'b0, 1'b1));
					back_to_seek();
				end else begin
					body_pos = '0;
					parse_phase = IN_BODY;
				end
			end
		end else if (parse_phase == IN_BODY) begin
			last = ({8'd0, body_pos} + 32'd1 >= cap_body_size);
			expected_results.push_back(frame_result(pvd_pkg::KIND_PAYLOAD, it.data_byte,
				body_pos == 24'd0, last));
			body_pos = body_pos + 24'd1;
			if (last)
				back_to_seek();
		end else if ({sig_history, it.data_byte} == pvd_pkg::SIGNATURE) begin
			cap_codec = '0;
			cap_hdr_size = '0;
			cap_body_size = '0;
			cap_width = '0;
			cap_height = '0;
			cap_stamp = '0;
			hdr_pos = 16'd4;
			body_pos = '0;
			sig_history = '0;
			parse_phase = IN_HEADER;
		end else begin
			sig_history = {sig_history[15:0], it.data_byte};
		end
	endfunction

	task automatic check_result(input pvd_pkg::result_t got, input pvd_pkg::result_t want);
		if (got.kind !== want.kind)
			report_mismatch("kind", 32'(got.kind), 32'(want.kind));
		if (got.payload_byte !== want.payload_byte)
			report_mismatch("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
		if (got.first_of_frame !== want.first_of_frame)
			report_mismatch("first_of_frame", 32'(got.first_of_frame), 32'(want.first_of_frame));
		if (got.last_of_frame !== want.last_of_frame)
			report_mismatch("last_of_frame", 32'(got.last_of_frame), 32'(want.last_of_frame));
		if (got.codec !== want.codec)
			report_mismatch("codec", 32'(got.codec), 32'(want.codec));
		if (got.pic_width !== want.pic_width)
			report_mismatch("pic_width", 32'(got.pic_width), 32'(want.pic_width));
		if (got.pic_height !== want.pic_height)
			report_mismatch("pic_height", 32'(got.pic_height), 32'(want.pic_height));
		if (got.timestamp_ms !== want.timestamp_ms)
			report_mismatch("timestamp_ms", got.timestamp_ms, want.timestamp_ms);
		if (got.payload_length !== want.payload_length)
			report_mismatch("payload_length", 32'(got.payload_length), 32'(want.payload_length));
	endtask

	// monitor: result beat first, it always belongs to an earlier input beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected result, kind", 32'(result.kind), 32'd0);
				else
					check_result(result, expected_results.pop_front());
			end
			if (item_valid && !item_stall) begin
				predict_item(item);
				items_taken++;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_pave_video_deframer_core NOT OK");
			$finish;
		end
	end

	// input driver: next beat once the current one is taken, random gaps between beats
	always @(negedge clk) begin
		if (items_offered == items_taken) begin
			if (send_gap != 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (outbound.size() != 0) begin
				item <= outbound.pop_front();
				item_valid <= 1'b1;
				items_offered++;
				if (!calm) begin
					if (send_quiet != 0)
						send_quiet--;
					else if ($urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(1, 6);
						if ($urandom_range(0, 3) == 0)
							send_quiet = $urandom_range(20, 80);
					end
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// output stall: random bursts plus one long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (want_hold && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (!calm && recv_quiet == 0 && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 5);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if (recv_quiet != 0)
				recv_quiet--;
			else if (!calm && $urandom_range(0, 30) == 0)
				recv_quiet = $urandom_range(20, 80);
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		pvd_pkg::item_t beat;
		beat.mode = pvd_pkg::MODE_BYTE;
		beat.data_byte = b;
		outbound.push_back(beat);
		queued_total++;
	endtask

	task automatic queue_restart();
		pvd_pkg::item_t beat;
		beat.mode = pvd_pkg::MODE_RESTART;
		beat.data_byte = 8'($urandom);
		outbound.push_back(beat);
		queued_total++;
	endtask

	function automatic logic [7:0] pick_byte(int fill);
		if (fill == FILL_ZEROS)
			return 8'h00;
		else if (fill == FILL_ONES)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_codec();
		case ($urandom_range(0, 2))
			0: return pvd_pkg::HDR_CODEC_AVC;
			1: return pvd_pkg::HDR_CODEC_M4V;
			default: return 8'($urandom);
		endcase
	endfunction

	// random bytes, sometimes opening with a broken signature
	task automatic queue_noise(input int count);
		if ($urandom_range(0, 3) == 0) begin
			queue_byte(pvd_pkg::SIGNATURE[31:24]);
			queue_byte(pvd_pkg::SIGNATURE[23:16]);
			queue_byte(pvd_pkg::SIGNATURE[15:8]);
		end
		repeat (count)
			queue_byte(8'($urandom));
	endtask

	// one frame: signature, header of hsize bytes (at least 8), body_bytes of payload;
	// a restart replaces everything from byte cut_at on when cut_at >= 0
	task automatic queue_frame(input int hsize, input logic [31:0] psize,
			input logic [7:0] codec, input int body_bytes, input int cut_at, input int fill);
		logic [7:0]  bytes[$];
		logic [7:0]  b;
		logic [15:0] hsz;
		logic [15:0] w;
		logic [15:0] h;
		logic [31:0] stamp;
		int          hdr_len;
		hsz = hsize[15:0];
		w = (fill == FILL_RANDOM) ? 16'($urandom) : {pick_byte(fill), pick_byte(fill)};
		h = (fill == FILL_RANDOM) ? 16'($urandom) : {pick_byte(fill), pick_byte(fill)};
		stamp = (fill == FILL_RANDOM) ? $urandom : {4{pick_byte(fill)}};
		hdr_len = (hsize < 8) ? 8 : hsize;
		for (int i = 0; i < hdr_len; i++) begin
			case (i)
				0, 1, 2, 3: b = pvd_pkg::SIGNATURE[8 * (3 - i) +: 8];
				5: b = codec;
				6: b = hsz[7:0];
				7: b = hsz[15:8];
				8, 9, 10, 11: b = psize[8 * (i - 8) +: 8];
				16: b = w[7:0];
				17: b = w[15:8];
				18: b = h[7:0];
				19: b = h[15:8];
				24, 25, 26, 27: b = stamp[8 * (i - 24) +: 8];
				default: b = pick_byte(fill);
			endcase
			bytes.push_back(b);
		end
		repeat (body_bytes)
			bytes.push_back(pick_byte(fill));
		for (int k = 0; k < bytes.size() && k != cut_at; k++)
			queue_byte(bytes[k]);
		if (cut_at >= 0)
			queue_restart();
	endtask

	// mostly well-formed frames, with noise, cuts, short and oversize headers
	task automatic queue_random_traffic(input int budget);
		int          stop_at;
		int          pick;
		int          hsize;
		int          room;
		logic [31:0] psize;
		logic [7:0]  codec;
		stop_at = queued_total + budget;
		while (queued_total < stop_at) begin
			pick = $urandom_range(0, 99);
			hsize = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 64) : 28;
			room = int'(frame_limit) - hsize;
			if (room > 48)
				room = 48;
			psize = $urandom_range(0, room);
			codec = pick_codec();
			if (pick < 8)
				queue_noise($urandom_range(1, 6));
			else if (pick < 10)
				queue_restart();
			else if (pick < 15)
				queue_frame($urandom_range(0, 27), psize, codec, 0, -1, FILL_RANDOM);
			else if (pick < 20) begin
				if ($urandom_range(0, 1) == 0)
					psize = 32'(frame_limit) - 32'(hsize) + 32'd1 + $urandom_range(0, 50);
				else
					psize = {8'($urandom_range(1, 255)), 24'($urandom)};
				queue_frame(hsize, psize, codec, 0, -1, FILL_RANDOM);
			end else if (pick < 28)
				queue_frame(hsize, psize, codec, int'(psize),
					$urandom_range(4, hsize + int'(psize) - 1), FILL_RANDOM);
			else
				queue_frame(hsize, psize, codec, int'(psize), -1, FILL_RANDOM);
		end
	endtask

	// wait until every beat is through and every result is back
	task automatic settle();
		while (outbound.size() != 0 || items_offered != items_taken
				|| expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_frame_limit(input logic [24:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		frame_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset size limit
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(pvd_pkg::SIGNATURE[31:24]);
		queue_byte(pvd_pkg::SIGNATURE[23:16]);
		queue_byte(pvd_pkg::SIGNATURE[15:8]);
		queue_restart();
		queue_frame(28, 32'd3, pvd_pkg::HDR_CODEC_AVC, 3, -1, FILL_ONES);
		queue_frame(28, 32'd1, pvd_pkg::HDR_CODEC_M4V, 1, -1, FILL_ZEROS);
		queue_frame(32, 32'd2, 8'd9, 2, -1, FILL_RANDOM);
		queue_frame(28, 32'd0, 8'd0, 0, -1, FILL_RANDOM);
		queue_frame(27, 32'd5, pvd_pkg::HDR_CODEC_AVC, 0, -1, FILL_RANDOM);
		queue_frame(0, 32'd5, pvd_pkg::HDR_CODEC_AVC, 0, -1, FILL_RANDOM);
		queue_frame(28, 32'd65509, pvd_pkg::HDR_CODEC_AVC, 0, -1, FILL_RANDOM);
		queue_frame(28, 32'd65508, pvd_pkg::HDR_CODEC_M4V, 2, 30, FILL_RANDOM);
		queue_frame(28, 32'h0100_0000, pvd_pkg::HDR_CODEC_AVC, 0, -1, FILL_RANDOM);
		queue_frame(28, 32'd4, pvd_pkg::HDR_CODEC_AVC, 4, 10, FILL_RANDOM);
		queue_frame(28, 32'd4, pvd_pkg::HDR_CODEC_AVC, 4, 4, FILL_RANDOM);
		queue_frame(28, 32'd4, pvd_pkg::HDR_CODEC_M4V, 4, 30, FILL_RANDOM);
		settle();

		// smallest limit: boundary around header plus payload of 64
		write_frame_limit(25'd64);
		queue_frame(28, 32'd36, pvd_pkg::HDR_CODEC_AVC, 36, -1, FILL_RANDOM);
		queue_frame(28, 32'd37, pvd_pkg::HDR_CODEC_AVC, 0, -1, FILL_RANDOM);
		queue_frame(64, 32'd0, pvd_pkg::HDR_CODEC_M4V, 0, -1, FILL_RANDOM);
		queue_frame(64, 32'd1, pvd_pkg::HDR_CODEC_M4V, 0, -1, FILL_RANDOM);
		settle();

		// largest limit: huge accepted frame cut short, then just over
		write_frame_limit(25'd16777216);
		queue_frame(28, 32'hFF_FFE4, pvd_pkg::HDR_CODEC_AVC, 3, 31, FILL_RANDOM);
		queue_frame(28, 32'hFF_FFE5, pvd_pkg::HDR_CODEC_AVC, 0, -1, FILL_RANDOM);
		queue_frame(28, 32'hFF_FFFF, pvd_pkg::HDR_CODEC_M4V, 0, -1, FILL_RANDOM);
		settle();

		// random traffic with a mid-size limit and one long output hold-off
		write_frame_limit(25'($urandom_range(64, 400)));
		queue_random_traffic(300);
		want_hold = 1'b1;
		settle();

		// closing stretch at the reset limit without any idling
		write_frame_limit(pvd_pkg::MAX_FRAME_RESET);
		calm = 1'b1;
		queue_random_traffic(100);
		settle();
		repeat (8) @(posedge clk);

		if (expected_results.size() != 0)
			report_mismatch("results still missing", 32'(expected_results.size()), 32'd0);
		if (mismatch_count == 0)
			$display("tb_pave_video_deframer_core OK");
		else
			$display("tb_pave_video_deframer_core NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/pvd_pkg.sv
hw/rtl/pvd_parse.sv
hw/rtl/pave_video_deframer_core.sv
hw/rtl/pvd_checker.sv
bench/tb_pave_video_deframer_core.sv
